### hdl/mhp_pkg.sv
// Shared types and codes for the message header parser.
package mhp_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  field_id;
        logic [63:0] value;
        logic [2:0]  status;
        logic        last;
    } t_out_item;

    typedef enum logic [3:0] {
        PH_MF    = 4'd0,
        PH_SESS  = 4'd1,
        PH_SF    = 4'd2,
        PH_CTR   = 4'd3,
        PH_SRC   = 4'd4,
        PH_DST   = 4'd5,
        PH_XF    = 4'd6,
        PH_OP    = 4'd7,
        PH_EXCH  = 4'd8,
        PH_PROTO = 4'd9,
        PH_VEND  = 4'd10,
        PH_ACK   = 4'd11,
        PH_PAY   = 4'd12,
        PH_DROP  = 4'd13
    } t_phase;

    localparam logic [1:0] KIND_FIELD   = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    localparam logic [3:0] FID_DESTNODE  = 4'd5;
    localparam logic [3:0] FID_DESTGROUP = 4'd6;
    localparam logic [3:0] FID_NONE      = 4'd0;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_RSV_DSIZ  = 3'd1;
    localparam logic [2:0] ST_MSG_EXT   = 3'd2;
    localparam logic [2:0] ST_SEC_EXT   = 3'd3;
    localparam logic [2:0] ST_TRUNC     = 3'd4;

    localparam logic [7:0] DEST_SIZE_MASK = 8'h03;
    localparam logic [1:0] DSIZ_NONE    = 2'd0;
    localparam logic [1:0] DSIZ_NODE    = 2'd1;
    localparam logic [1:0] DSIZ_GROUP   = 2'd2;
    localparam logic [1:0] DSIZ_RSV     = 2'd3;
    localparam logic [7:0] MF_SOURCE    = 8'h10;
    localparam logic [7:0] SF_MSG_EXT   = 8'h20;
    localparam logic [7:0] XF_SEC_EXT   = 8'h08;
    localparam logic [7:0] XF_VENDOR    = 8'h10;
    localparam logic [7:0] XF_ACK       = 8'h02;

endpackage

### hdl/mhp_result_fifo.sv
// Result queue that takes up to two results per cycle and gives one.
module mhp_result_fifo #(
    parameter int DEPTH = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [1:0]                    i_push_n,
    input  mhp_pkg::t_out_item            i_item0,
    input  mhp_pkg::t_out_item            i_item1,
    input  logic                          i_pop,
    output logic                          o_valid,
    output mhp_pkg::t_out_item            o_item,
    output logic [$clog2(DEPTH+1)-1:0]    o_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    mhp_pkg::t_out_item r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr, r_rd, n_rd, w_wr1;
    logic [CW-1:0] r_count, n_count;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH-1)) ? '0 : p + AW'(1);
    endfunction

    assign w_wr1 = ptr_inc(r_wr);

    always_comb begin
        n_wr = r_wr;
        if (i_push_n == 2'd1) begin
            n_wr = w_wr1;
        end else if (i_push_n == 2'd2) begin
            n_wr = ptr_inc(w_wr1);
        end
        n_rd    = i_pop ? ptr_inc(r_rd) : r_rd;
        n_count = r_count + CW'(i_push_n) - CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wr] <= i_item0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[w_wr1] <= i_item1;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];
    assign o_count = r_count;

endmodule

### hdl/message_header_parser.sv
// Top level of the streaming message header parser.
// One frame byte is taken per transfer and a new byte can be taken every cycle while the input
// is not stalled. A byte is held in the input register and parsed from there, and its results
// (none, one, or a field or payload result followed by the end-of-frame status) enter an
// eight-entry result queue, from which the output is read. The output gives one result per
// cycle while it is not stalled; the only bytes that give two results are final bytes, and the
// input stalls when the queue cannot take the results of the bytes already in flight.
module message_header_parser #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  mhp_pkg::t_in_item   i_in_item,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output mhp_pkg::t_out_item  o_out_item,
    input  logic                i_out_stall
);

    localparam int FifoDepth = 8;
    localparam int CntW      = $clog2(FifoDepth+1);

    logic               r_in_valid;
    mhp_pkg::t_in_item  r_in;

    mhp_pkg::t_phase    r_phase, n_phase;
    logic [2:0]         r_bif, n_bif;
    logic [63:0]        r_acc, n_acc;
    logic [7:0]         r_mflags, n_mflags;
    logic [7:0]         r_xflags, n_xflags;
    logic [2:0]         r_err, n_err;
    logic [LENGTH_BITS-1:0] r_pay_cnt, n_pay_cnt;

    mhp_pkg::t_out_item w_item0, w_item1, w_prim, w_stat;
    logic               w_prim_vld;
    logic [1:0]         w_push_n;
    logic [63:0]        w_word;
    logic [2:0]         w_bif_inc;
    logic [CntW-1:0]    w_count;
    logic [CntW:0]      w_need;
    logic               w_in_xfer;

    function automatic logic [2:0] field_size(input mhp_pkg::t_phase ph, input logic [7:0] mf);
        logic [2:0] sz;
        unique case (ph)
            mhp_pkg::PH_SESS, mhp_pkg::PH_EXCH,
            mhp_pkg::PH_PROTO, mhp_pkg::PH_VEND: sz = 3'd2;
            mhp_pkg::PH_CTR, mhp_pkg::PH_ACK:    sz = 3'd4;
            mhp_pkg::PH_SRC:                     sz = 3'd0;
            mhp_pkg::PH_DST: sz = ((mf & mhp_pkg::DEST_SIZE_MASK) == 8'(mhp_pkg::DSIZ_NODE))
                                  ? 3'd0 : 3'd2;
            default:                             sz = 3'd1;
        endcase
        return sz;
    endfunction

    function automatic logic [3:0] field_code(input mhp_pkg::t_phase ph, input logic [7:0] mf);
        logic [3:0] code;
        if (ph == mhp_pkg::PH_DST) begin
            code = ((mf & mhp_pkg::DEST_SIZE_MASK) == 8'(mhp_pkg::DSIZ_NODE))
                   ? mhp_pkg::FID_DESTNODE : mhp_pkg::FID_DESTGROUP;
        end else if (ph > mhp_pkg::PH_DST) begin
            code = 4'(ph) + 4'd1;
        end else begin
            code = 4'(ph);
        end
        return code;
    endfunction

    function automatic mhp_pkg::t_phase next_phase(input mhp_pkg::t_phase ph,
                                                   input logic [7:0] mf,
                                                   input logic [7:0] xf,
                                                   input logic [2:0] err);
        mhp_pkg::t_phase nx;
        mhp_pkg::t_phase to_proto;
        mhp_pkg::t_phase to_end;
        mhp_pkg::t_phase after_dst;
        mhp_pkg::t_phase after_proto;
        logic [1:0] dsiz;
        dsiz        = 2'(mf & mhp_pkg::DEST_SIZE_MASK);
        to_proto    = (err != mhp_pkg::ST_OK) ? mhp_pkg::PH_DROP : mhp_pkg::PH_XF;
        to_end      = (err != mhp_pkg::ST_OK) ? mhp_pkg::PH_DROP : mhp_pkg::PH_PAY;
        after_dst   = (dsiz == mhp_pkg::DSIZ_NODE || dsiz == mhp_pkg::DSIZ_GROUP)
                      ? mhp_pkg::PH_DST : to_proto;
        after_proto = ((xf & mhp_pkg::XF_VENDOR) != 8'h00) ? mhp_pkg::PH_VEND :
                      ((xf & mhp_pkg::XF_ACK) != 8'h00)    ? mhp_pkg::PH_ACK  : to_end;
        unique case (ph)
            mhp_pkg::PH_MF:    nx = mhp_pkg::PH_SESS;
            mhp_pkg::PH_SESS:  nx = mhp_pkg::PH_SF;
            mhp_pkg::PH_SF:    nx = mhp_pkg::PH_CTR;
            mhp_pkg::PH_CTR:   nx = ((mf & mhp_pkg::MF_SOURCE) != 8'h00)
                                    ? mhp_pkg::PH_SRC : after_dst;
            mhp_pkg::PH_SRC:   nx = after_dst;
            mhp_pkg::PH_DST:   nx = to_proto;
            mhp_pkg::PH_XF:    nx = mhp_pkg::PH_OP;
            mhp_pkg::PH_OP:    nx = mhp_pkg::PH_EXCH;
            mhp_pkg::PH_EXCH:  nx = mhp_pkg::PH_PROTO;
            mhp_pkg::PH_PROTO: nx = after_proto;
            mhp_pkg::PH_VEND:  nx = ((xf & mhp_pkg::XF_ACK) != 8'h00)
                                    ? mhp_pkg::PH_ACK : to_end;
            default:           nx = to_end;
        endcase
        return nx;
    endfunction

    assign w_need     = (CntW+1)'(w_count) + (r_in_valid ? (CntW+1)'(2) : '0);
    assign o_in_stall = (w_need > (CntW+1)'(FifoDepth-2));
    assign w_in_xfer  = i_in_valid && !o_in_stall;

    assign w_bif_inc = r_bif + 3'd1;
    assign w_word    = r_acc | ({56'd0, r_in.data_byte} << {r_bif, 3'b000});

    always_comb begin
        n_phase    = r_phase;
        n_bif      = r_bif;
        n_acc      = r_acc;
        n_mflags   = r_mflags;
        n_xflags   = r_xflags;
        n_err      = r_err;
        n_pay_cnt  = r_pay_cnt;
        w_prim_vld = 1'b0;
        w_prim     = '0;
        w_stat     = '0;
        w_item0    = '0;
        w_item1    = '0;
        w_push_n   = 2'd0;

        if (r_in_valid) begin
            if (r_phase == mhp_pkg::PH_PAY) begin
                w_prim_vld     = 1'b1;
                w_prim.kind    = mhp_pkg::KIND_PAYLOAD;
                w_prim.value   = {56'd0, r_in.data_byte};
                if (r_pay_cnt != '1) begin
                    n_pay_cnt = r_pay_cnt + LENGTH_BITS'(1);
                end
            end else if (r_phase != mhp_pkg::PH_DROP) begin
                n_bif = w_bif_inc;
                n_acc = w_word;
                if (w_bif_inc == field_size(r_phase, r_mflags)) begin
                    w_prim_vld     = 1'b1;
                    w_prim.kind    = mhp_pkg::KIND_FIELD;
                    w_prim.field_id = field_code(r_phase, r_mflags);
                    w_prim.value   = w_word;
                    if (r_phase == mhp_pkg::PH_MF) begin
                        n_mflags = r_in.data_byte;
                    end else if (r_phase == mhp_pkg::PH_SF) begin
                        if ((r_in.data_byte & mhp_pkg::SF_MSG_EXT) != 8'h00 &&
                            r_err == mhp_pkg::ST_OK) begin
                            n_err = mhp_pkg::ST_MSG_EXT;
                        end
                    end else if (r_phase == mhp_pkg::PH_XF) begin
                        n_xflags = r_in.data_byte;
                        if ((r_in.data_byte & mhp_pkg::XF_SEC_EXT) != 8'h00 &&
                            r_err == mhp_pkg::ST_OK) begin
                            n_err = mhp_pkg::ST_SEC_EXT;
                        end
                    end
                    if (r_phase == mhp_pkg::PH_MF &&
                        2'(r_in.data_byte & mhp_pkg::DEST_SIZE_MASK) == mhp_pkg::DSIZ_RSV) begin
                        n_err   = mhp_pkg::ST_RSV_DSIZ;
                        n_phase = mhp_pkg::PH_DROP;
                    end else begin
                        n_phase = next_phase(r_phase, n_mflags, n_xflags, n_err);
                    end
                    n_bif = 3'd0;
                    n_acc = '0;
                end
            end

            w_stat.kind     = mhp_pkg::KIND_STATUS;
            w_stat.field_id = mhp_pkg::FID_NONE;
            w_stat.last     = 1'b1;
            if (n_phase == mhp_pkg::PH_PAY) begin
                w_stat.status = mhp_pkg::ST_OK;
                w_stat.value  = 64'(n_pay_cnt);
            end else if (n_err != mhp_pkg::ST_OK) begin
                w_stat.status = n_err;
            end else begin
                w_stat.status = mhp_pkg::ST_TRUNC;
            end

            if (w_prim_vld) begin
                w_item0  = w_prim;
                w_item1  = w_stat;
                w_push_n = r_in.frame_end ? 2'd2 : 2'd1;
            end else if (r_in.frame_end) begin
                w_item0  = w_stat;
                w_push_n = 2'd1;
            end

            if (r_in.frame_end) begin
                n_phase   = mhp_pkg::PH_MF;
                n_bif     = 3'd0;
                n_acc     = '0;
                n_mflags  = 8'h00;
                n_xflags  = 8'h00;
                n_err     = mhp_pkg::ST_OK;
                n_pay_cnt = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= mhp_pkg::PH_MF;
            r_bif      <= 3'd0;
            r_acc      <= '0;
            r_mflags   <= 8'h00;
            r_xflags   <= 8'h00;
            r_err      <= mhp_pkg::ST_OK;
            r_pay_cnt  <= '0;
        end else begin
            r_in_valid <= w_in_xfer;
            r_phase    <= n_phase;
            r_bif      <= n_bif;
            r_acc      <= n_acc;
            r_mflags   <= n_mflags;
            r_xflags   <= n_xflags;
            r_err      <= n_err;
            r_pay_cnt  <= n_pay_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in <= i_in_item;
        end
    end

    mhp_result_fifo #(
        .DEPTH (FifoDepth)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (w_push_n),
        .i_item0  (w_item0),
        .i_item1  (w_item1),
        .i_pop    (o_out_valid && !i_out_stall),
        .o_valid  (o_out_valid),
        .o_item   (o_out_item),
        .o_count  (w_count)
    );

endmodule

### hdl/mhp_checker.sv
// Port-level checks for the message header parser, bound to the top level.
module mhp_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input mhp_pkg::t_in_item   i_in_item,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input mhp_pkg::t_out_item  o_out_item,
    input logic                i_out_stall
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    a_payload_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.kind == mhp_pkg::KIND_PAYLOAD |->
            o_out_item.field_id == mhp_pkg::FID_NONE && o_out_item.status == mhp_pkg::ST_OK
            && !o_out_item.last && o_out_item.value[63:8] == 56'd0)
        else $error("malformed payload result");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.kind == mhp_pkg::KIND_STATUS) != o_out_item.last |-> 1'b0)
        else $error("last mark not on status result");

endmodule

bind message_header_parser mhp_checker u_mhp_checker (.*);

### tb/tb_message_header_parser.sv
// Testbench for the message header parser: directed and random frames against a predictor.
`timescale 1ns / 100ps

module tb_message_header_parser;
    import mhp_pkg::*;

    localparam int LEN_BITS = 16;

    localparam logic [3:0] FID_MSGFLAGS = 4'd0;
    localparam logic [3:0] FID_SESSION  = 4'd1;
    localparam logic [3:0] FID_SECFLAGS = 4'd2;
    localparam logic [3:0] FID_COUNTER  = 4'd3;
    localparam logic [3:0] FID_SOURCE   = 4'd4;
    localparam logic [3:0] FID_XFLAGS   = 4'd7;
    localparam logic [3:0] FID_OPCODE   = 4'd8;
    localparam logic [3:0] FID_EXCHANGE = 4'd9;
    localparam logic [3:0] FID_PROTOCOL = 4'd10;
    localparam logic [3:0] FID_VENDOR   = 4'd11;
    localparam logic [3:0] FID_ACKCTR   = 4'd12;

    localparam int NUM_DIRECTED  = 26;
    localparam int RANDOM_ITEMS  = 1100;
    localparam int RX_HOLD_LEN   = 200;
    localparam int MAX_PRINTED   = 100;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
        logic       typed;
        t_out_item  want;
    } t_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    t_in_item   i_in_item;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_item  o_out_item;
    logic       i_out_stall;

    t_phase                hp_phase;
    int unsigned           hp_nbytes;
    logic [63:0]           hp_acc;
    logic [7:0]            hp_mflags;
    logic [7:0]            hp_xflags;
    logic [2:0]            hp_err;
    logic [LEN_BITS-1:0]   hp_paylen;

    t_out_item   parse_out[$];
    t_out_item   pending_results[$];
    logic [7:0]  frame_bytes[$];
    t_row        directed [NUM_DIRECTED];

    int  mismatches = 0;
    bit  tx_quiet = 1'b0;
    bit  rx_quiet = 1'b0;
    bit  rx_hold_req = 1'b0;

    message_header_parser #(
        .LENGTH_BITS(LEN_BITS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic t_out_item make_res(logic [1:0] k, logic [3:0] id, logic [63:0] v,
                                           logic [2:0] st, logic lst);
        t_out_item r;
        r.kind     = k;
        r.field_id = id;
        r.value    = v;
        r.status   = st;
        r.last     = lst;
        return r;
    endfunction

    function automatic int unsigned width_of(t_phase ph);
        case (ph)
            PH_SESS, PH_EXCH, PH_PROTO, PH_VEND: return 2;
            PH_CTR, PH_ACK:                      return 4;
            PH_SRC:                              return 8;
            PH_DST: return (hp_mflags[1:0] == DSIZ_NODE) ? 8 : 2;
            default:                             return 1;
        endcase
    endfunction

    function automatic logic [3:0] id_of(t_phase ph);
        case (ph)
            PH_MF:    return FID_MSGFLAGS;
            PH_SESS:  return FID_SESSION;
            PH_SF:    return FID_SECFLAGS;
            PH_CTR:   return FID_COUNTER;
            PH_SRC:   return FID_SOURCE;
            PH_DST:   return (hp_mflags[1:0] == DSIZ_NODE) ? FID_DESTNODE : FID_DESTGROUP;
            PH_XF:    return FID_XFLAGS;
            PH_OP:    return FID_OPCODE;
            PH_EXCH:  return FID_EXCHANGE;
            PH_PROTO: return FID_PROTOCOL;
            PH_VEND:  return FID_VENDOR;
            default:  return FID_ACKCTR;
        endcase
    endfunction

    function automatic t_phase after_field(t_phase ph);
        t_phase hdr_done;
        t_phase proto_start;
        t_phase dest_or_proto;
        hdr_done = (hp_err != ST_OK) ? PH_DROP : PH_PAY;
        proto_start = (hp_err != ST_OK) ? PH_DROP : PH_XF;
        dest_or_proto = (hp_mflags[1:0] == DSIZ_NODE || hp_mflags[1:0] == DSIZ_GROUP) ?
                        PH_DST : proto_start;
        case (ph)
            PH_MF:    return PH_SESS;
            PH_SESS:  return PH_SF;
            PH_SF:    return PH_CTR;
            PH_CTR:   return ((hp_mflags & MF_SOURCE) != 8'd0) ? PH_SRC : dest_or_proto;
            PH_SRC:   return dest_or_proto;
            PH_DST:   return proto_start;
            PH_XF:    return PH_OP;
            PH_OP:    return PH_EXCH;
            PH_EXCH:  return PH_PROTO;
            PH_PROTO: begin
                if ((hp_xflags & XF_VENDOR) != 8'd0) return PH_VEND;
                if ((hp_xflags & XF_ACK) != 8'd0) return PH_ACK;
                return hdr_done;
            end
            PH_VEND:  return ((hp_xflags & XF_ACK) != 8'd0) ? PH_ACK : hdr_done;
            default:  return hdr_done;
        endcase
    endfunction

    task automatic parser_reset();
        hp_phase  = PH_MF;
        hp_nbytes = 0;
        hp_acc    = '0;
        hp_mflags = '0;
        hp_xflags = '0;
        hp_err    = ST_OK;
        hp_paylen = '0;
    endtask

    task automatic parse_byte(input t_in_item it);
        t_phase ph;
        parse_out.delete();
        if (hp_phase == PH_PAY) begin
            parse_out.push_back(make_res(KIND_PAYLOAD, FID_NONE, 64'(it.data_byte), ST_OK, 1'b0));
            if (hp_paylen != '1) hp_paylen = hp_paylen + LEN_BITS'(1);
        end else if (hp_phase != PH_DROP) begin
            hp_acc = hp_acc | (64'(it.data_byte) << (8 * hp_nbytes));
            hp_nbytes = hp_nbytes + 1;
            if (hp_nbytes == width_of(hp_phase)) begin
                ph = hp_phase;
                parse_out.push_back(make_res(KIND_FIELD, id_of(ph), hp_acc, ST_OK, 1'b0));
                if (ph == PH_MF) hp_mflags = it.data_byte;
                if (ph == PH_SF && (it.data_byte & SF_MSG_EXT) != 8'd0 && hp_err == ST_OK)
                    hp_err = ST_MSG_EXT;
                if (ph == PH_XF) begin
                    hp_xflags = it.data_byte;
                    if ((it.data_byte & XF_SEC_EXT) != 8'd0 && hp_err == ST_OK)
                        hp_err = ST_SEC_EXT;
                end
                if (ph == PH_MF && it.data_byte[1:0] == DSIZ_RSV) begin
                    hp_err = ST_RSV_DSIZ;
                    hp_phase = PH_DROP;
                end else begin
                    hp_phase = after_field(ph);
                end
                hp_nbytes = 0;
                hp_acc = '0;
            end
        end
        if (it.frame_end) begin
            if (hp_phase == PH_PAY)
                parse_out.push_back(make_res(KIND_STATUS, FID_NONE, 64'(hp_paylen), ST_OK, 1'b1));
            else
                parse_out.push_back(make_res(KIND_STATUS, FID_NONE, 64'd0,
                                             (hp_err != ST_OK) ? hp_err : ST_TRUNC, 1'b1));
            parser_reset();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < MAX_PRINTED)
            $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (pending_results.size() == 0) begin
            report_mismatch("unexpected result, value", got.value, 64'd0);
        end else begin
            want = pending_results.pop_front();
            if (got.kind != want.kind)
                report_mismatch("kind", 64'(got.kind), 64'(want.kind));
            if (got.field_id != want.field_id)
                report_mismatch("field_id", 64'(got.field_id), 64'(want.field_id));
            if (got.value != want.value) report_mismatch("value", got.value, want.value);
            if (got.status != want.status)
                report_mismatch("status", 64'(got.status), 64'(want.status));
            if (got.last != want.last)
                report_mismatch("last", 64'(got.last), 64'(want.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) check_result(o_out_item);
    end

    task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
                             input t_out_item want);
        int unsigned gap;
        t_in_item    it;
        if ($urandom_range(0, 49) == 0) tx_quiet = !tx_quiet;
        gap = tx_quiet ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        it.data_byte = b;
        it.frame_end = fin;
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        parse_byte(it);
        if (typed)
            pending_results.push_back(want);
        else
            foreach (parse_out[i]) pending_results.push_back(parse_out[i]);
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1, 1'b0, '0);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic add_random(input int unsigned n);
        repeat (n) frame_bytes.push_back(8'($urandom));
    endtask

    task automatic build_frame();
        logic [7:0]  mflags;
        logic [7:0]  sflags;
        logic [7:0]  xflags;
        int unsigned cut;
        frame_bytes.delete();
        if ($urandom_range(0, 3) == 0) begin
            add_random($urandom_range(1, 24));
        end else begin
            mflags = 8'($urandom);
            mflags[1:0] = 2'($urandom_range(DSIZ_NONE, DSIZ_GROUP));
            sflags = 8'($urandom);
            if ($urandom_range(0, 7) != 0) sflags = sflags & ~SF_MSG_EXT;
            xflags = 8'($urandom);
            if ($urandom_range(0, 7) != 0) xflags = xflags & ~XF_SEC_EXT;
            frame_bytes.push_back(mflags);
            add_random(2);
            frame_bytes.push_back(sflags);
            add_random(4);
            if ((mflags & MF_SOURCE) != 8'd0) add_random(8);
            if (mflags[1:0] == DSIZ_NODE) add_random(8);
            if (mflags[1:0] == DSIZ_GROUP) add_random(2);
            frame_bytes.push_back(xflags);
            add_random(5);
            if ((xflags & XF_VENDOR) != 8'd0) add_random(2);
            if ((xflags & XF_ACK) != 8'd0) add_random(4);
            add_random($urandom_range(0, 12));
            if ($urandom_range(0, 5) == 0) begin
                cut = $urandom_range(1, frame_bytes.size() - 1);
                while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
            end
        end
    endtask

    initial begin : rx_side
        int unsigned hold;
        i_out_stall = 1'b0;
        wait (i_rst_n);
        forever begin
            if (rx_hold_req) begin
                hold = RX_HOLD_LEN;
                rx_hold_req = 1'b0;
            end else begin
                if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
                hold = rx_quiet ? 0 : $urandom_range(0, 10);
            end
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin
        #50_000_000;
        $display("[message_header_parser] ERROR");
        $finish;
    end

    initial begin : main
        int random_items;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_item  = '0;
        random_items = 0;
        parser_reset();
        directed = '{
            // reserved destination size, rest of frame dropped
            '{8'h03, 1'b0, 1'b1, make_res(KIND_FIELD, FID_MSGFLAGS, 64'h3, ST_OK, 1'b0)},
            '{8'hFF, 1'b1, 1'b1, make_res(KIND_STATUS, FID_NONE, 64'd0, ST_RSV_DSIZ, 1'b1)},
            // one-byte frame, truncated
            '{8'h00, 1'b1, 1'b0, '0},
            // message extensions, frame ends on the counter
            '{8'h00, 1'b0, 1'b1, make_res(KIND_FIELD, FID_MSGFLAGS, 64'h0, ST_OK, 1'b0)},
            '{8'hFF, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b1, make_res(KIND_FIELD, FID_SESSION, 64'hFFFF, ST_OK, 1'b0)},
            '{8'h20, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b1, 1'b0, '0},
            // minimal header and one payload byte
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b1, make_res(KIND_FIELD, FID_SESSION, 64'h0, ST_OK, 1'b0)},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h01, 1'b0, 1'b0, '0},
            '{8'h02, 1'b0, 1'b0, '0},
            '{8'h03, 1'b0, 1'b0, '0},
            '{8'h04, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b1, make_res(KIND_FIELD, FID_OPCODE, 64'hFF, ST_OK, 1'b0)},
            '{8'hAA, 1'b0, 1'b0, '0},
            '{8'h55, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b1, 1'b0, '0}
        };
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i])
            send_byte(directed[i].data, directed[i].fin, directed[i].typed, directed[i].want);
        drain();

        rx_hold_req = 1'b1;
        while (random_items < RANDOM_ITEMS) begin
            build_frame();
            send_frame();
            random_items += frame_bytes.size();
        end
        drain();

        repeat (16) @(posedge i_clk);
        if (mismatches == 0)
            $display("[message_header_parser] OK");
        else
            $display("[message_header_parser] ERROR");
        $finish;
    end

endmodule
